// ===== rtl/core/chtr_pkg.sv =====
package chtr_pkg;

    // Fixed field widths of the request and result beats.
    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;
    localparam int CFG_W = 11;
    localparam int TEN_W = 4;

    // Load thresholds are given in tenths.
    localparam int TENTHS = 10;

    // Register reset values.
    localparam logic [CNT_W-1:0] RST_MIN_BUCKETS = 11'd16;
    localparam logic [TEN_W-1:0] RST_GROW_TENTHS = 4'd7;
    localparam logic [TEN_W-1:0] RST_SHRINK_TENTHS = 4'd2;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_GET    = 2'd1,
        REQ_DELETE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_PRESENT = 3'd1,
        STS_ABSENT  = 3'd2,
        STS_NO_ROOM = 3'd3,
        STS_NULL    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CFG_MIN_BUCKETS   = 2'd0,
        CFG_GROW_TENTHS   = 2'd1,
        CFG_SHRINK_TENTHS = 2'd2,
        CFG_HOLD_SIZE     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } chtr_in_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [VAL_W-1:0] value_out;
        logic [CNT_W-1:0] entry_total;
        logic [CNT_W-1:0] bucket_total;
    } chtr_out_t;

    typedef struct packed {
        logic [CNT_W-1:0] min_buckets;
        logic [TEN_W-1:0] grow_tenths;
        logic [TEN_W-1:0] shrink_tenths;
        logic             hold_size;
    } chtr_cfg_t;

    typedef enum logic [4:0] {
        S_SWEEP,
        S_IDLE,
        S_DIV,
        S_HEAD,
        S_WALK,
        S_CMP,
        S_INS_WR,
        S_DEL_FREE,
        S_LOAD,
        S_GH_RD,
        S_GH_GOT,
        S_GN_RD,
        S_GN_GOT,
        S_RD_NODE,
        S_RD_KEY,
        S_RD_DIV,
        S_RD_HEAD,
        S_DONE
    } state_t;

endpackage

// ===== rtl/core/chained_hash_table_with_resize_top.sv =====
// Insert, get and delete hash the key with the 64-step remainder unit and then walk the
// chain one node at a time. A rehash visits every old bucket and hashes each entry anew;
// key, value and link in the node pool share a single read port.
// Clear sweeps every entry of the larger of bucket table and node pool.
// Reset is asynchronous and active low; after it the same sweep runs before the
// first request beat is taken. One request is in work at a time.
module chained_hash_table_with_resize_top
    import chtr_pkg::*;
#(
    parameter int MAX_BUCKETS  = 1024,
    parameter int POOL_ENTRIES = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  chtr_in_t         in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output chtr_out_t        out_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    chtr_cfg_t cfg_reg, cfg_next;
    logic      req_ready, res_valid, res_take;
    chtr_out_t res;
    logic      out_valid_reg, out_valid_next;
    chtr_out_t out_data_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MIN_BUCKETS:   cfg_next.min_buckets   = cfg_data;
                CFG_GROW_TENTHS:   cfg_next.grow_tenths   = cfg_data[TEN_W-1:0];
                CFG_SHRINK_TENTHS: cfg_next.shrink_tenths = cfg_data[TEN_W-1:0];
                CFG_HOLD_SIZE:     cfg_next.hold_size     = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_buckets   <= RST_MIN_BUCKETS;
            cfg_reg.grow_tenths   <= RST_GROW_TENTHS;
            cfg_reg.shrink_tenths <= RST_SHRINK_TENTHS;
            cfg_reg.hold_size     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    chtr_core #(
        .MAX_BUCKETS  (MAX_BUCKETS),
        .POOL_ENTRIES (POOL_ENTRIES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (in_valid),
        .req       (in_data),
        .req_ready (req_ready),
        .res_valid (res_valid),
        .res_take  (res_take),
        .res       (res)
    );

    assign in_stall = !req_ready;

    // Output register: a finished beat waits here while the core takes the next one.
    assign res_take = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The input stalls right after a request beat is taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("request taken on consecutive cycles");

    // Only a successful get carries a value.
    a_value_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == STS_OK || out_data.value_out == '0))
        else $error("value returned with a failing status");

    // Counts stay within the pool and the bucket range.
    a_totals_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.entry_total <= POOL_ENTRIES &&
                       out_data.bucket_total != '0 &&
                       out_data.bucket_total <= MAX_BUCKETS))
        else $error("entry or bucket total out of range");

endmodule

// ===== rtl/core/chtr_rem.sv =====
module chtr_rem
    import chtr_pkg::*;
#(
    parameter int DIV_W = 11
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [KEY_W-1:0]    dividend,
    input  logic [DIV_W-1:0]    divisor,
    output logic                done,
    output logic [DIV_W-1:0]    remainder
);

    localparam int BC_W = $clog2(KEY_W);

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [BC_W-1:0]     cnt_reg, cnt_next;
    logic [KEY_W-1:0]    sh_reg, sh_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [DIV_W:0]      trial;

    // One restoring step per cycle, most significant dividend bit first.
    assign trial = {rem_reg, sh_reg[KEY_W-1]};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            sh_next  = dividend;
            rem_next = '0;
            div_next = divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            sh_next  = {sh_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg + BC_W'(1);
            if (cnt_reg == BC_W'(KEY_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/chtr_core.sv =====
module chtr_core
    import chtr_pkg::*;
#(
    parameter int MAX_BUCKETS  = 1024,
    parameter int POOL_ENTRIES = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  chtr_cfg_t  cfg,
    input  logic       req_valid,
    input  chtr_in_t   req,
    output logic       req_ready,
    output logic       res_valid,
    input  logic       res_take,
    output chtr_out_t  res
);

    localparam int BW    = $clog2(MAX_BUCKETS);
    localparam int CW    = $clog2(MAX_BUCKETS + 1);
    localparam int PW    = $clog2(POOL_ENTRIES);
    localparam int NW    = $clog2(POOL_ENTRIES + 1);
    localparam int SWEEP = (MAX_BUCKETS > POOL_ENTRIES) ? MAX_BUCKETS : POOL_ENTRIES;
    localparam int SIW   = $clog2(SWEEP);
    localparam int SW    = ((CW + 1) > (CNT_W + 1)) ? (CW + 1) : (CNT_W + 1);
    localparam int LW    = ((NW > CW) ? NW : CW) + TEN_W;
    localparam int RST_BK = (MAX_BUCKETS < int'(RST_MIN_BUCKETS)) ? MAX_BUCKETS
                                                                  : int'(RST_MIN_BUCKETS);
    localparam logic [NW-1:0] NIL = NW'(POOL_ENTRIES);

    // Memories.
    logic [NW-1:0]    bh_mem   [MAX_BUCKETS];
    logic [KEY_W-1:0] key_mem  [POOL_ENTRIES];
    logic [VAL_W-1:0] val_mem  [POOL_ENTRIES];
    logic [NW-1:0]    link_mem [POOL_ENTRIES];

    logic             bh_we, link_we, kv_we;
    logic [BW-1:0]    bh_waddr, bh_raddr;
    logic [NW-1:0]    bh_wdata, bh_rd;
    logic [PW-1:0]    link_waddr, node_raddr, kv_waddr;
    logic [NW-1:0]    link_wdata, link_rd;
    logic [KEY_W-1:0] key_rd;
    logic [VAL_W-1:0] val_rd;

    // Sequencer registers.
    state_t           state_reg, state_next;
    logic             clr_pend_reg, clr_pend_next;
    logic [SIW-1:0]   sweep_reg, sweep_next;
    logic [NW-1:0]    free_reg, free_next;
    logic [NW-1:0]    ent_reg, ent_next;
    logic [CW-1:0]    bkt_reg, bkt_next;
    logic [CW-1:0]    nsize_reg, nsize_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [NW-1:0]    prev_reg, prev_next;
    logic [NW-1:0]    head_reg, head_next;
    logic [NW-1:0]    walk_reg, walk_next;
    logic [NW-1:0]    all_reg, all_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [BW-1:0]    gidx_reg, gidx_next;
    logic [1:0]       rtype_reg, rtype_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [2:0]       sts_reg, sts_next;
    logic [VAL_W-1:0] vout_reg, vout_next;

    // Shared remainder unit.
    logic             div_start, div_done;
    logic [KEY_W-1:0] div_dividend;
    logic [CW-1:0]    div_rem;

    chtr_rem #(.DIV_W(CW)) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (bkt_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Load test and target size for a rehash.
    logic [LW-1:0] load10, grow_lim, shrink_lim;
    logic          grow_hit, shrink_hit;
    logic [SW-1:0] min_ext, floor_sz, cand_raw, cand_sz;
    logic          last_bucket;

    always_comb
    begin
        load10     = LW'(ent_reg) * LW'(TENTHS);
        grow_lim   = LW'(cfg.grow_tenths) * LW'(bkt_reg);
        shrink_lim = LW'(cfg.shrink_tenths) * LW'(bkt_reg);
        grow_hit   = load10 > grow_lim;
        shrink_hit = load10 < shrink_lim;
        min_ext    = SW'(cfg.min_buckets);
        if (min_ext == SW'(0))
        begin
            floor_sz = SW'(1);
        end
        else if (min_ext > SW'(MAX_BUCKETS))
        begin
            floor_sz = SW'(MAX_BUCKETS);
        end
        else
        begin
            floor_sz = min_ext;
        end
        cand_raw = grow_hit ? (SW'(bkt_reg) << 1) : (SW'(bkt_reg) >> 1);
        if (cand_raw < floor_sz)
        begin
            cand_sz = floor_sz;
        end
        else if (cand_raw > SW'(MAX_BUCKETS))
        begin
            cand_sz = SW'(MAX_BUCKETS);
        end
        else
        begin
            cand_sz = cand_raw;
        end
    end

    assign last_bucket = (CW'(gidx_reg) == (bkt_reg - CW'(1)));

    // Next state, memory controls and register updates.
    always_comb
    begin
        state_next    = state_reg;
        clr_pend_next = clr_pend_reg;
        sweep_next    = sweep_reg;
        free_next     = free_reg;
        ent_next      = ent_reg;
        bkt_next      = bkt_reg;
        nsize_next    = nsize_reg;
        cur_next      = cur_reg;
        prev_next     = prev_reg;
        head_next     = head_reg;
        walk_next     = walk_reg;
        all_next      = all_reg;
        b_next        = b_reg;
        gidx_next     = gidx_reg;
        rtype_next    = rtype_reg;
        key_next      = key_reg;
        val_next      = val_reg;
        sts_next      = sts_reg;
        vout_next     = vout_reg;
        bh_we         = 1'b0;
        bh_waddr      = b_reg;
        bh_wdata      = NIL;
        bh_raddr      = b_reg;
        link_we       = 1'b0;
        link_waddr    = cur_reg[PW-1:0];
        link_wdata    = NIL;
        kv_we         = 1'b0;
        kv_waddr      = free_reg[PW-1:0];
        node_raddr    = cur_reg[PW-1:0];
        div_start     = 1'b0;
        div_dividend  = req.key;
        req_ready     = 1'b0;
        res_valid     = 1'b0;

        unique case (state_reg)
            S_SWEEP:
            begin
                if (sweep_reg < SIW'(MAX_BUCKETS - 1) || SWEEP == MAX_BUCKETS ||
                    sweep_reg == SIW'(MAX_BUCKETS - 1))
                begin
                    bh_we    = 1'b1;
                    bh_waddr = sweep_reg[BW-1:0];
                end
                if (sweep_reg < SIW'(POOL_ENTRIES - 1) || SWEEP == POOL_ENTRIES ||
                    sweep_reg == SIW'(POOL_ENTRIES - 1))
                begin
                    link_we    = 1'b1;
                    link_waddr = sweep_reg[PW-1:0];
                    link_wdata = NW'(sweep_reg) + NW'(1);
                end
                sweep_next = sweep_reg + SIW'(1);
                if (sweep_reg == SIW'(SWEEP - 1))
                begin
                    free_next  = '0;
                    ent_next   = '0;
                    sts_next   = STS_OK;
                    vout_next  = '0;
                    state_next = clr_pend_reg ? S_DONE : S_IDLE;
                    clr_pend_next = 1'b0;
                end
            end

            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    rtype_next = req.req_type;
                    key_next   = req.key;
                    val_next   = req.value_in;
                    vout_next  = '0;
                    sts_next   = STS_OK;
                    if (req.req_type == REQ_CLEAR)
                    begin
                        clr_pend_next = 1'b1;
                        sweep_next    = '0;
                        state_next    = S_SWEEP;
                    end
                    else if (req.req_type == REQ_INSERT && req.value_in == '0)
                    begin
                        sts_next   = STS_NULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                bh_raddr = div_rem[BW-1:0];
                if (div_done)
                begin
                    b_next     = div_rem[BW-1:0];
                    state_next = S_HEAD;
                end
            end

            S_HEAD:
            begin
                cur_next   = bh_rd;
                head_next  = bh_rd;
                prev_next  = NIL;
                state_next = S_WALK;
            end

            S_WALK:
            begin
                if (cur_reg == NIL)
                begin
                    if (rtype_reg != REQ_INSERT)
                    begin
                        sts_next   = STS_ABSENT;
                        state_next = S_DONE;
                    end
                    else if (free_reg == NIL)
                    begin
                        sts_next   = STS_NO_ROOM;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Fetch the successor of the free head.
                        node_raddr = free_reg[PW-1:0];
                        state_next = S_INS_WR;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end

            S_CMP:
            begin
                if (key_rd == key_reg)
                begin
                    unique case (rtype_reg)
                        REQ_GET:
                        begin
                            vout_next  = val_rd;
                            state_next = S_DONE;
                        end
                        REQ_INSERT:
                        begin
                            sts_next   = STS_PRESENT;
                            state_next = S_DONE;
                        end
                        REQ_DELETE, REQ_CLEAR:
                        begin
                            // Unlink the node and keep the rest of the chain.
                            if (prev_reg != NIL)
                            begin
                                link_we    = 1'b1;
                                link_waddr = prev_reg[PW-1:0];
                                link_wdata = link_rd;
                            end
                            else
                            begin
                                bh_we    = 1'b1;
                                bh_wdata = link_rd;
                            end
                            state_next = S_DEL_FREE;
                        end
                    endcase
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = link_rd;
                    node_raddr = link_rd[PW-1:0];
                    state_next = S_WALK;
                end
            end

            S_INS_WR:
            begin
                kv_we      = 1'b1;
                link_we    = 1'b1;
                link_waddr = free_reg[PW-1:0];
                link_wdata = head_reg;
                bh_we      = 1'b1;
                bh_wdata   = free_reg;
                free_next  = link_rd;
                ent_next   = ent_reg + NW'(1);
                state_next = S_LOAD;
            end

            S_DEL_FREE:
            begin
                link_we    = 1'b1;
                link_wdata = free_reg;
                free_next  = cur_reg;
                ent_next   = ent_reg - NW'(1);
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                if ((grow_hit || shrink_hit) && !cfg.hold_size &&
                    cand_sz != SW'(bkt_reg))
                begin
                    nsize_next = CW'(cand_sz);
                    gidx_next  = '0;
                    all_next   = NIL;
                    state_next = S_GH_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_GH_RD:
            begin
                bh_raddr   = gidx_reg;
                state_next = S_GH_GOT;
            end

            S_GH_GOT:
            begin
                bh_we    = 1'b1;
                bh_waddr = gidx_reg;
                if (bh_rd == NIL)
                begin
                    if (last_bucket)
                    begin
                        bkt_next   = nsize_reg;
                        walk_next  = all_reg;
                        state_next = S_RD_NODE;
                    end
                    else
                    begin
                        gidx_next  = gidx_reg + BW'(1);
                        state_next = S_GH_RD;
                    end
                end
                else
                begin
                    walk_next  = bh_rd;
                    state_next = S_GN_RD;
                end
            end

            S_GN_RD:
            begin
                node_raddr = walk_reg[PW-1:0];
                state_next = S_GN_GOT;
            end

            S_GN_GOT:
            begin
                // Push the node onto the gathered list.
                link_we    = 1'b1;
                link_waddr = walk_reg[PW-1:0];
                link_wdata = all_reg;
                all_next   = walk_reg;
                walk_next  = link_rd;
                if (link_rd != NIL)
                begin
                    state_next = S_GN_RD;
                end
                else if (last_bucket)
                begin
                    bkt_next   = nsize_reg;
                    walk_next  = walk_reg;
                    state_next = S_RD_NODE;
                end
                else
                begin
                    gidx_next  = gidx_reg + BW'(1);
                    state_next = S_GH_RD;
                end
            end

            S_RD_NODE:
            begin
                node_raddr = walk_reg[PW-1:0];
                state_next = (walk_reg == NIL) ? S_DONE : S_RD_KEY;
            end

            S_RD_KEY:
            begin
                cur_next     = link_rd;
                div_start    = 1'b1;
                div_dividend = key_rd;
                state_next   = S_RD_DIV;
            end

            S_RD_DIV:
            begin
                bh_raddr = div_rem[BW-1:0];
                if (div_done)
                begin
                    b_next     = div_rem[BW-1:0];
                    state_next = S_RD_HEAD;
                end
            end

            S_RD_HEAD:
            begin
                link_we    = 1'b1;
                link_waddr = walk_reg[PW-1:0];
                link_wdata = bh_rd;
                bh_we      = 1'b1;
                bh_wdata   = walk_reg;
                walk_next  = cur_reg;
                state_next = S_RD_NODE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The gathered list starts with the last node pushed and ends with the first.
    always_comb
    begin
        res.status       = sts_reg;
        res.value_out    = vout_reg;
        res.entry_total  = CNT_W'(ent_reg);
        res.bucket_total = CNT_W'(bkt_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_SWEEP;
            clr_pend_reg <= 1'b0;
            sweep_reg    <= '0;
            free_reg     <= '0;
            ent_reg      <= '0;
            bkt_reg      <= CW'(RST_BK);
        end
        else
        begin
            state_reg    <= state_next;
            clr_pend_reg <= clr_pend_next;
            sweep_reg    <= sweep_next;
            free_reg     <= free_next;
            ent_reg      <= ent_next;
            bkt_reg      <= bkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nsize_reg <= nsize_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        head_reg  <= head_next;
        walk_reg  <= walk_next;
        all_reg   <= all_next;
        b_reg     <= b_next;
        gidx_reg  <= gidx_next;
        rtype_reg <= rtype_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        sts_reg   <= sts_next;
        vout_reg  <= vout_next;
    end

    // Bucket heads: at most one write and one registered read each cycle.
    always_ff @(posedge clk)
    begin
        if (bh_we)
        begin
            bh_mem[bh_waddr] <= bh_wdata;
        end
        bh_rd <= bh_mem[bh_raddr];
    end

    // Node pool: key, value and link share one read address.
    always_ff @(posedge clk)
    begin
        if (kv_we)
        begin
            key_mem[kv_waddr] <= key_reg;
            val_mem[kv_waddr] <= val_reg;
        end
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        key_rd  <= key_mem[node_raddr];
        val_rd  <= val_mem[node_raddr];
        link_rd <= link_mem[node_raddr];
    end

endmodule
